/* rtl/psdes_pkg.sv */
// Shared types, constants and round keys for the pseudo-DES random generator.
`default_nettype none

package psdes_pkg;

    localparam int ROUNDS_DEF = 4;
    localparam int ROUNDS_MAX = 4;
    localparam int WORD_W     = 32;
    localparam int HALF_W     = 16;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED_HIGH = 2'd0,
        REG_SEED_LOW  = 2'd1
    } cfg_reg_t;

    localparam logic [WORD_W-1:0] KEY_A [ROUNDS_MAX] = '{
        32'hbaa96887, 32'h1e17d32c, 32'h03bcdc3c, 32'h0f33d1b2
    };
    localparam logic [WORD_W-1:0] KEY_B [ROUNDS_MAX] = '{
        32'h4b0f3b58, 32'he874f0c3, 32'h6955c5a6, 32'h55a7ca46
    };

    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] block_high;
        logic [WORD_W-1:0] block_low;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] hash_high;
        logic [WORD_W-1:0] hash_low;
    } res_t;

    typedef struct packed {
        logic [WORD_W-1:0] l;
        logic [WORD_W-1:0] r;
    } lr_t;

endpackage

`default_nettype wire

/* rtl/psdes_src.sv */
// Seed registers, draw counter and the input stage that picks the word to hash.
`default_nettype none

module psdes_src (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  req_valid,
    output logic                                       req_ready,
    input  wire psdes_pkg::req_t                       req_data,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [psdes_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [psdes_pkg::WORD_W-1:0]          cfg_data,
    output logic                                       word_valid,
    input  wire logic                                  word_ready,
    output psdes_pkg::lr_t                             word
);

    logic [psdes_pkg::WORD_W-1:0]   seed_high_reg, seed_high_next;
    logic [psdes_pkg::WORD_W-1:0]   seed_low_reg, seed_low_next;
    logic [2*psdes_pkg::WORD_W-1:0] cnt_reg, cnt_next;
    logic                           valid_reg, valid_next;
    psdes_pkg::lr_t                 word_reg, word_next;
    logic                           load;
    logic                           take;
    logic                           cfg_wr;

    assign load      = !valid_reg || word_ready;
    assign req_ready = load;
    assign take      = req_valid && load;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        seed_high_next = seed_high_reg;
        seed_low_next  = seed_low_reg;
        cnt_next       = cnt_reg;
        if (take && !req_data.mode)
        begin
            cnt_next = cnt_reg + 64'd1;
        end
        if (cfg_wr)
        begin
            unique case (psdes_pkg::cfg_reg_t'(cfg_index))
                psdes_pkg::REG_SEED_HIGH:
                begin
                    seed_high_next = cfg_data;
                    cnt_next       = {cfg_data, seed_low_reg};
                end
                psdes_pkg::REG_SEED_LOW:
                begin
                    seed_low_next = cfg_data;
                    cnt_next      = {seed_high_reg, cfg_data};
                end
                default:
                begin
                    cnt_next = cnt_next;
                end
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (load)
        begin
            valid_next = req_valid;
        end
        if (take)
        begin
            if (req_data.mode)
            begin
                word_next = '{l: req_data.block_high, r: req_data.block_low};
            end
            else
            begin
                word_next = '{l: cnt_reg[2*psdes_pkg::WORD_W-1:psdes_pkg::WORD_W],
                              r: cnt_reg[psdes_pkg::WORD_W-1:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_high_reg <= '0;
            seed_low_reg  <= '0;
            cnt_reg       <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            seed_high_reg <= seed_high_next;
            seed_low_reg  <= seed_low_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

/* rtl/psdes_round.sv */
// One Feistel round in two register stages: squares and product, then mix and swap.
`default_nettype none

module psdes_round #(
    parameter int KEY_IDX = 0
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire psdes_pkg::lr_t s_word,
    output logic                m_valid,
    input  wire logic           m_ready,
    output psdes_pkg::lr_t      m_word
);

    localparam logic [psdes_pkg::WORD_W-1:0] KA = psdes_pkg::KEY_A[KEY_IDX];
    localparam logic [psdes_pkg::WORD_W-1:0] KB = psdes_pkg::KEY_B[KEY_IDX];

    logic                          a_valid_reg, a_valid_next;
    logic [psdes_pkg::WORD_W-1:0]  a_l_reg, a_r_reg;
    logic [psdes_pkg::WORD_W-1:0]  sq_lo_reg, sq_hi_reg, prod_reg;
    logic                          b_valid_reg, b_valid_next;
    psdes_pkg::lr_t                b_word_reg;

    logic                          a_load, b_load;
    logic [psdes_pkg::WORD_W-1:0]  x;
    logic [psdes_pkg::HALF_W-1:0]  x_lo, x_hi;
    logic [psdes_pkg::WORD_W-1:0]  sq_lo, sq_hi, prod;
    logic [psdes_pkg::WORD_W-1:0]  sum, rot, f;

    assign b_load  = !b_valid_reg || m_ready;
    assign a_load  = !a_valid_reg || b_load;
    assign s_ready = a_load;

    assign x     = s_word.r ^ KA;
    assign x_lo  = x[psdes_pkg::HALF_W-1:0];
    assign x_hi  = x[psdes_pkg::WORD_W-1:psdes_pkg::HALF_W];
    assign sq_lo = x_lo * x_lo;
    assign sq_hi = x_hi * x_hi;
    assign prod  = x_lo * x_hi;

    assign sum = sq_lo_reg + ~sq_hi_reg;
    assign rot = {sum[psdes_pkg::HALF_W-1:0], sum[psdes_pkg::WORD_W-1:psdes_pkg::HALF_W]};
    assign f   = (rot ^ KB) + prod_reg;

    assign a_valid_next = a_load ? s_valid : a_valid_reg;
    assign b_valid_next = b_load ? a_valid_reg : b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_l_reg   <= s_word.l;
            a_r_reg   <= s_word.r;
            sq_lo_reg <= sq_lo;
            sq_hi_reg <= sq_hi;
            prod_reg  <= prod;
        end
        if (b_load)
        begin
            b_word_reg <= '{l: a_r_reg, r: a_l_reg ^ f};
        end
    end

    assign m_valid = b_valid_reg;
    assign m_word  = b_word_reg;

endmodule

`default_nettype wire

/* rtl/psdes_counter_random_generator.sv */
// Top level of the counter-based pseudo-DES random generator.
//
//  channel | direction | payload                          | handshake
//  req     | in        | mode, block_high, block_low      | req_valid / req_ready
//  res     | out       | hash_high, hash_low              | res_valid / res_ready
//  cfg     | in        | cfg_index, cfg_data (seed words) | cfg_valid / cfg_ready
//
// One request per cycle unless res stalls; the pipeline is one input stage, then
// two stages per round: the 16x16 squares and product, then the mix and swap.
// Reset clears all valid bits, both seeds and the draw counter; no clearing pass.
// A stall on res holds each stage in place; empty stages still take new requests.
`default_nettype none

module psdes_counter_random_generator #(
    parameter int ROUNDS = psdes_pkg::ROUNDS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire psdes_pkg::req_t                 req_data,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output psdes_pkg::res_t                      res_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [psdes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [psdes_pkg::WORD_W-1:0]    cfg_data
);

    logic           stg_valid [ROUNDS+1];
    logic           stg_ready [ROUNDS+1];
    psdes_pkg::lr_t stg_word  [ROUNDS+1];

    psdes_src u_src (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .word_valid (stg_valid[0]),
        .word_ready (stg_ready[0]),
        .word       (stg_word[0])
    );

    for (genvar i = 0; i < ROUNDS; i++)
    begin : g_round
        psdes_round #(
            .KEY_IDX (i)
        ) u_round (
            .clk     (clk),
            .rst_n   (rst_n),
            .s_valid (stg_valid[i]),
            .s_ready (stg_ready[i]),
            .s_word  (stg_word[i]),
            .m_valid (stg_valid[i+1]),
            .m_ready (stg_ready[i+1]),
            .m_word  (stg_word[i+1])
        );
    end

    assign stg_ready[ROUNDS] = res_ready;
    assign res_valid         = stg_valid[ROUNDS];
    assign res_data          = '{hash_high: stg_word[ROUNDS].l, hash_low: stg_word[ROUNDS].r};

endmodule

`default_nettype wire

/* rtl/psdes_chk.sv */
// Port-level checker for the random generator and its bind to the top level.
`default_nettype none

module psdes_chk #(
    parameter int ROUNDS = psdes_pkg::ROUNDS_DEF
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            req_valid,
    input wire logic                            req_ready,
    input wire logic                            res_valid,
    input wire logic                            res_ready,
    input wire psdes_pkg::res_t                 res_data,
    input wire logic                            cfg_valid,
    input wire logic                            cfg_ready
);

    localparam int DEPTH = 1 + 2 * ROUNDS;
    localparam int CNT_W = $clog2(DEPTH + 2);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             req_take, res_take;

    assign req_take = req_valid && req_ready;
    assign res_take = res_valid && res_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (req_take && !res_take)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (res_take && !req_take)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result dropped or changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> cnt_reg != '0)
        else $error("result without an outstanding request");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("more requests in flight than pipeline stages");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write blocked");

endmodule

bind psdes_counter_random_generator psdes_chk #(.ROUNDS(ROUNDS)) u_psdes_chk (.*);

`default_nettype wire

/* test/psdes_counter_random_generator_test.sv */
// Self-checking testbench for the counter-based pseudo-DES random generator.
`default_nettype none

module psdes_counter_random_generator_test;

    localparam int LATENCY     = 1 + 2 * psdes_pkg::ROUNDS_DEF;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASES      = 13;
    localparam int PHASE_ITEMS = 150;

    localparam logic [psdes_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [psdes_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [127:0] ROUND_KEYS_A =
        {32'h0f33d1b2, 32'h03bcdc3c, 32'h1e17d32c, 32'hbaa96887};
    localparam logic [127:0] ROUND_KEYS_B =
        {32'h55a7ca46, 32'h6955c5a6, 32'he874f0c3, 32'h4b0f3b58};

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_ready;
    psdes_pkg::req_t                 req_data  = '0;
    logic                            res_valid;
    logic                            res_ready = 1'b0;
    psdes_pkg::res_t                 res_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [psdes_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [psdes_pkg::WORD_W-1:0]    cfg_data  = '0;

    psdes_pkg::res_t              pending_hashes[$];
    logic [63:0]                  draw_count;
    logic [psdes_pkg::WORD_W-1:0] seed_hi_word;
    logic [psdes_pkg::WORD_W-1:0] seed_lo_word;
    int                           errors           = 0;
    bit                           idle_enable      = 1'b1;
    bit                           stall_enable     = 1'b1;
    bit                           hold_off_pending = 1'b0;
    int                           hold_left        = 0;
    int                           stall_left       = 0;

    psdes_counter_random_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic [psdes_pkg::WORD_W-1:0] round_mix(
        input logic [psdes_pkg::WORD_W-1:0] r, input int k);
        logic [psdes_pkg::WORD_W-1:0] a;
        logic [psdes_pkg::WORD_W-1:0] lo;
        logic [psdes_pkg::WORD_W-1:0] hi;
        logic [psdes_pkg::WORD_W-1:0] sum;
        logic [psdes_pkg::WORD_W-1:0] rot;
        a   = r ^ ROUND_KEYS_A[k*32 +: 32];
        lo  = {16'h0000, a[15:0]};
        hi  = {16'h0000, a[31:16]};
        sum = lo * lo + ~(hi * hi);
        rot = {sum[15:0], sum[31:16]};
        return (rot ^ ROUND_KEYS_B[k*32 +: 32]) + lo * hi;
    endfunction

    function automatic psdes_pkg::res_t feistel_hash(
        input logic [psdes_pkg::WORD_W-1:0] left_in,
        input logic [psdes_pkg::WORD_W-1:0] right_in);
        logic [psdes_pkg::WORD_W-1:0] l;
        logic [psdes_pkg::WORD_W-1:0] r;
        logic [psdes_pkg::WORD_W-1:0] old_r;
        int                           n;
        psdes_pkg::res_t              h;
        l = left_in;
        r = right_in;
        n = (psdes_pkg::ROUNDS_DEF > psdes_pkg::ROUNDS_MAX) ? psdes_pkg::ROUNDS_MAX :
            ((psdes_pkg::ROUNDS_DEF < 1) ? 1 : psdes_pkg::ROUNDS_DEF);
        for (int k = 0; k < n; k++)
        begin
            old_r = r;
            r     = l ^ round_mix(old_r, k);
            l     = old_r;
        end
        h.hash_high = l;
        h.hash_low  = r;
        return h;
    endfunction

    task automatic record_expected_hash(input psdes_pkg::req_t rq);
        if (rq.mode)
        begin
            pending_hashes.push_back(feistel_hash(rq.block_high, rq.block_low));
        end
        else
        begin
            pending_hashes.push_back(feistel_hash(draw_count[63:32], draw_count[31:0]));
            draw_count = draw_count + 64'd1;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        else
            return $urandom_range(20, 40);
    endfunction

    task automatic send_request(input psdes_pkg::req_t rq);
        int gap;
        gap = (idle_enable && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= rq;
        do @(posedge clk); while (!req_ready);
        record_expected_hash(rq);
    endtask

    task automatic send_fields(input logic mode, input logic [psdes_pkg::WORD_W-1:0] hi,
                               input logic [psdes_pkg::WORD_W-1:0] lo);
        psdes_pkg::req_t rq;
        rq.mode       = mode;
        rq.block_high = hi;
        rq.block_low  = lo;
        send_request(rq);
    endtask

    task automatic drain_pipeline();
        req_valid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge clk);
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    task automatic write_register(input logic [psdes_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [psdes_pkg::WORD_W-1:0] d);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == psdes_pkg::REG_SEED_HIGH)
        begin
            seed_hi_word = d;
            draw_count   = {seed_hi_word, seed_lo_word};
        end
        else if (idx == psdes_pkg::REG_SEED_LOW)
        begin
            seed_lo_word = d;
            draw_count   = {seed_hi_word, seed_lo_word};
        end
    endtask

    task automatic check_result(input psdes_pkg::res_t got);
        psdes_pkg::res_t want;
        if (pending_hashes.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h %h",
                     $time, got.hash_high, got.hash_low);
        end
        else
        begin
            want = pending_hashes.pop_front();
            if (got.hash_high !== want.hash_high)
            begin
                errors++;
                $display("%0t: hash_high mismatch, expected %h, actual %h",
                         $time, want.hash_high, got.hash_high);
            end
            if (got.hash_low !== want.hash_low)
            begin
                errors++;
                $display("%0t: hash_low mismatch, expected %h, actual %h",
                         $time, want.hash_low, got.hash_low);
            end
        end
    endtask

    // Receiver: check each accepted result, then pick res_ready for the next cycle.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (res_valid && res_ready)
                check_result(res_data);
            if (hold_off_pending)
            begin
                hold_left        = HOLD_CYCLES;
                hold_off_pending = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
                if (stall_enable && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic test_draws_after_reset();
        send_fields(1'b0, 32'h0000_0000, 32'h0000_0000);
        send_fields(1'b0, 32'hffff_ffff, 32'hffff_ffff);
        send_fields(1'b0, $urandom, $urandom);
        send_fields(1'b0, $urandom, $urandom);
    endtask

    task automatic test_supplied_words();
        send_fields(1'b1, 32'h0000_0000, 32'h0000_0000);
        send_fields(1'b1, 32'hffff_ffff, 32'hffff_ffff);
        send_fields(1'b1, 32'haaaa_aaaa, 32'h5555_5555);
        send_fields(1'b1, 32'h5555_5555, 32'haaaa_aaaa);
        send_fields(1'b1, 32'h8000_0000, 32'h0000_0001);
        send_fields(1'b1, $urandom, $urandom);
        // counter must not have moved
        send_fields(1'b0, $urandom, $urandom);
    endtask

    task automatic test_seed_reload();
        write_register(psdes_pkg::REG_SEED_HIGH, 32'hffff_ffff);
        write_register(psdes_pkg::REG_SEED_LOW, 32'hffff_fffe);
        repeat (3) send_fields(1'b0, $urandom, $urandom);
        write_register(CFG_SPARE_A, $urandom);
        write_register(CFG_SPARE_B, $urandom);
        send_fields(1'b0, $urandom, $urandom);
        write_register(psdes_pkg::REG_SEED_LOW, 32'hffff_ffff);
        send_fields(1'b0, $urandom, $urandom);
        write_register(psdes_pkg::REG_SEED_HIGH, 32'h0000_0000);
        repeat (2) send_fields(1'b0, $urandom, $urandom);
        write_register(psdes_pkg::REG_SEED_LOW, 32'h0000_0000);
        send_fields(1'b0, $urandom, $urandom);
    endtask

    task automatic test_output_hold_off();
        drain_pipeline();
        idle_enable      = 1'b0;
        hold_off_pending = 1'b1;
        repeat (40) send_fields(1'($urandom_range(0, 1)), $urandom, $urandom);
        idle_enable = 1'b1;
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < PHASES; p++)
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    write_register(psdes_pkg::REG_SEED_HIGH, $urandom);
                    write_register(psdes_pkg::REG_SEED_LOW, $urandom);
                end
                1:
                begin
                    write_register(psdes_pkg::REG_SEED_HIGH, $urandom);
                    write_register(psdes_pkg::REG_SEED_LOW,
                                   32'hffff_ffff - $urandom_range(0, 40));
                end
                2:
                begin
                    write_register(psdes_pkg::REG_SEED_HIGH, 32'hffff_ffff);
                    write_register(psdes_pkg::REG_SEED_LOW,
                                   32'hffff_ffff - $urandom_range(0, 40));
                end
                3:
                begin
                    write_register(psdes_pkg::REG_SEED_LOW, $urandom);
                    write_register(CFG_SPARE_A, $urandom);
                end
                default:
                begin
                    write_register(psdes_pkg::REG_SEED_HIGH, 32'h0000_0000);
                    write_register(CFG_SPARE_B, $urandom);
                end
            endcase
            idle_enable  = (p % 4 != 0);
            stall_enable = (p % 3 != 0);
            repeat (PHASE_ITEMS) send_fields(1'($urandom_range(0, 1)), $urandom, $urandom);
        end
        idle_enable  = 1'b1;
        stall_enable = 1'b1;
    endtask

    initial
    begin
        draw_count   = 64'd0;
        seed_hi_word = '0;
        seed_lo_word = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_draws_after_reset();
        test_supplied_words();
        test_seed_reload();
        test_output_hold_off();
        test_random_traffic();
        drain_pipeline();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(20 * 1000000);
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/psdes_pkg.sv
rtl/psdes_src.sv
rtl/psdes_round.sv
rtl/psdes_counter_random_generator.sv
rtl/psdes_chk.sv
test/psdes_counter_random_generator_test.sv
